// ----- src/qrbd_pkg.sv -----
// ----------------------------------------------------------------------------
// qrbd_pkg
// Types and constants shared by the quest record byte decoder.
// ----------------------------------------------------------------------------
package qrbd_pkg;

    // Field sizes of the record layout, in bytes
    localparam int C_HANDLE_BYTES = 8;
    localparam int C_WORD_BYTES   = 4;
    localparam int C_OBJ_BYTES    = 5;
    localparam int C_INDEX_BYTES  = C_OBJ_BYTES - 1;

    // Result queue depth: two resident results plus two from one byte
    localparam int C_QUEUE_DEPTH  = 4;

    // Header status flag masks
    localparam logic [2:0] C_FLAG_RUNNING  = 3'b001;
    localparam logic [2:0] C_FLAG_ACTIVE   = 3'b010;
    localparam logic [2:0] C_FLAG_COMPLETE = 3'b100;

    // Objective flag masks
    localparam logic [7:0] C_OBJ_DISPLAYED = 8'h01;
    localparam logic [7:0] C_OBJ_COMPLETED = 8'h02;

    typedef enum logic [2:0] {
        PH_DOMAIN   = 3'd0,
        PH_HANDLE   = 3'd1,
        PH_STAGE    = 3'd2,
        PH_FLAGS    = 3'd3,
        PH_COUNT    = 3'd4,
        PH_INDEX    = 3'd5,
        PH_OBJFLAGS = 3'd6,
        PH_DONE     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_OBJECTIVE = 2'd1,
        KIND_STATUS    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_TRAILING  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         domain;
        logic [63:0]        handle;
        logic signed [31:0] signed_value;
        logic               running;
        logic               active;
        logic               complete;
        logic [31:0]        objective_total;
        logic               displayed;
        logic               completed;
        t_status            status;
        logic               last;
    } t_result;

    // Results caused by one accepted byte: a field result, then a status
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_parse_out;

endpackage

// ----- src/qrbd_parser.sv -----
// ----------------------------------------------------------------------------
// qrbd_parser
// Record field state machine: assembles little-endian fields byte by byte
// and forms the header, objective and status results of each byte.
// ----------------------------------------------------------------------------
module qrbd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_record,
    output qrbd_pkg::t_parse_out o_res
);
    import qrbd_pkg::*;

    t_phase      r_phase, n_phase, s_phase;
    logic [2:0]  r_pos, n_pos, s_pos;
    logic [63:0] r_shift, n_shift;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_domain, n_domain;
    logic [63:0] r_handle, n_handle;
    logic [31:0] r_stage, n_stage;
    logic [2:0]  r_flags, n_flags;
    logic [63:0] gathered;
    logic        last_of_word;

    // Accumulator with the current byte merged in at its position
    always_comb begin
        gathered = (r_pos == 3'd0) ? 64'd0 : r_shift;
        gathered[{r_pos, 3'b000} +: 8] = i_data_byte;
    end

    assign last_of_word = (r_pos == 3'(C_WORD_BYTES - 1));

    // Next state
    always_comb begin
        s_phase  = r_phase;
        s_pos    = r_pos;
        n_shift  = r_shift;
        n_left   = r_left;
        n_domain = r_domain;
        n_handle = r_handle;
        n_stage  = r_stage;
        n_flags  = r_flags;
        unique case (r_phase)
            PH_DOMAIN: begin
                n_domain = i_data_byte;
                s_pos    = 3'd0;
                s_phase  = PH_HANDLE;
            end
            PH_HANDLE: begin
                n_shift = gathered;
                if (r_pos == 3'(C_HANDLE_BYTES - 1)) begin
                    s_pos    = 3'd0;
                    n_handle = gathered;
                    s_phase  = PH_STAGE;
                end else begin
                    s_pos = r_pos + 3'd1;
                end
            end
            PH_STAGE: begin
                n_shift = gathered;
                if (last_of_word) begin
                    s_pos   = 3'd0;
                    n_stage = gathered[31:0];
                    s_phase = PH_FLAGS;
                end else begin
                    s_pos = r_pos + 3'd1;
                end
            end
            PH_FLAGS: begin
                n_flags = i_data_byte[2:0];
                s_pos   = 3'd0;
                s_phase = PH_COUNT;
            end
            PH_COUNT: begin
                n_shift = gathered;
                if (last_of_word) begin
                    s_pos   = 3'd0;
                    n_left  = gathered[31:0];
                    s_phase = (gathered[31:0] == 32'd0) ? PH_DONE : PH_INDEX;
                end else begin
                    s_pos = r_pos + 3'd1;
                end
            end
            PH_INDEX: begin
                n_shift = gathered;
                if (r_pos == 3'(C_INDEX_BYTES - 1)) begin
                    s_pos   = 3'd0;
                    s_phase = PH_OBJFLAGS;
                end else begin
                    s_pos = r_pos + 3'd1;
                end
            end
            PH_OBJFLAGS: begin
                s_pos   = 3'd0;
                n_left  = r_left - 32'd1;
                s_phase = (r_left == 32'd1) ? PH_DONE : PH_INDEX;
            end
            PH_DONE: begin
                // mark bytes beyond the end of the record
                s_pos = 3'd1;
            end
        endcase

        n_phase = s_phase;
        n_pos   = s_pos;
        if (i_end_of_record) begin
            n_phase = PH_DOMAIN;
            n_pos   = 3'd0;
            n_shift = 64'd0;
            n_left  = 32'd0;
        end
    end

    // Result outputs
    always_comb begin
        o_res = '0;
        if (r_phase == PH_COUNT && last_of_word) begin
            o_res.a_valid           = i_accept;
            o_res.a.kind            = KIND_HEADER;
            o_res.a.domain          = r_domain;
            o_res.a.handle          = r_handle;
            o_res.a.signed_value    = r_stage;
            o_res.a.running         = |(r_flags & C_FLAG_RUNNING);
            o_res.a.active          = |(r_flags & C_FLAG_ACTIVE);
            o_res.a.complete        = |(r_flags & C_FLAG_COMPLETE);
            o_res.a.objective_total = gathered[31:0];
        end else if (r_phase == PH_OBJFLAGS) begin
            o_res.a_valid        = i_accept;
            o_res.a.kind         = KIND_OBJECTIVE;
            o_res.a.signed_value = r_shift[31:0];
            o_res.a.displayed    = |(i_data_byte & C_OBJ_DISPLAYED);
            o_res.a.completed    = |(i_data_byte & C_OBJ_COMPLETED);
        end
        o_res.a.last = !i_end_of_record;

        o_res.b_valid = i_accept && i_end_of_record;
        o_res.b.kind  = KIND_STATUS;
        if (s_phase != PH_DONE) begin
            o_res.b.status = ST_TRUNCATED;
        end else if (s_pos != 3'd0) begin
            o_res.b.status = ST_TRAILING;
        end else begin
            o_res.b.status = ST_OK;
        end
        o_res.b.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DOMAIN;
            r_pos   <= 3'd0;
            r_left  <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_shift  <= n_shift;
            r_domain <= n_domain;
            r_handle <= n_handle;
            r_stage  <= n_stage;
            r_flags  <= n_flags;
        end
    end

endmodule

// ----- src/qrbd_result_queue.sv -----
// ----------------------------------------------------------------------------
// qrbd_result_queue
// Four-entry shifting result queue: takes up to two results per cycle,
// delivers one per transfer from its head.
// ----------------------------------------------------------------------------
module qrbd_result_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qrbd_pkg::t_parse_out i_res,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output qrbd_pkg::t_result    o_head,
    output logic [2:0]           o_count
);
    import qrbd_pkg::*;

    t_result    r_slot [C_QUEUE_DEPTH];
    t_result    n_slot [C_QUEUE_DEPTH];
    logic [2:0] r_count, n_count;
    logic       pop;
    logic [2:0] base;
    logic [2:0] n_wr;
    t_result    first, second;

    assign pop   = (r_count != 3'd0) && !i_stall;
    assign base  = r_count - {2'b00, pop};
    assign n_wr  = {2'b00, i_res.a_valid} + {2'b00, i_res.b_valid};
    assign first  = i_res.a_valid ? i_res.a : i_res.b;
    assign second = i_res.b;

    always_comb begin
        for (int i = 0; i < C_QUEUE_DEPTH; i++) begin
            if (pop && i < C_QUEUE_DEPTH - 1) begin
                n_slot[i] = r_slot[i + 1];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (n_wr != 3'd0 && base == 3'(i)) begin
                n_slot[i] = first;
            end
            if (n_wr == 3'd2 && base + 3'd1 == 3'(i)) begin
                n_slot[i] = second;
            end
        end
        n_count = base + n_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < C_QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    // Leave room for two results from the next byte
    assign o_full  = (r_count >= 3'(C_QUEUE_DEPTH - 1));
    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_slot[0];
    assign o_count = r_count;

endmodule

// ----- src/quest_record_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// quest_record_byte_decoder
// Decodes a little-endian quest record one byte per cycle, while o_stall is
// low, into header, objective and record status results.
// ----------------------------------------------------------------------------
//   channel   | handshake          | payload
//   ----------+--------------------+------------------------------------------
//   input     | i_valid / o_stall  | i_data_byte, i_end_of_record
//   output    | o_valid / i_stall  | o_kind .. o_last, one result per transfer
//
// One byte per cycle while o_stall is low; the field state register and a
// four-entry result queue set that figure. A byte yields zero, one or two
// results. Two results from one byte while the output is stalled can leave
// three or four queued; o_stall is then high until two or fewer remain.
// Synchronous active-low reset empties the queue and returns to the domain
// field; no clearing pass.
// ----------------------------------------------------------------------------
module quest_record_byte_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_record,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_domain,
    output logic [63:0]        o_handle,
    output logic signed [31:0] o_signed_value,
    output logic               o_running,
    output logic               o_active,
    output logic               o_complete,
    output logic [31:0]        o_objective_total,
    output logic               o_displayed,
    output logic               o_completed,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import qrbd_pkg::*;

    logic       accept;
    logic       full;
    logic [2:0] count;
    t_parse_out res;
    t_result    head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    qrbd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_record (i_end_of_record),
        .o_res           (res)
    );

    qrbd_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head),
        .o_count (count)
    );

    assign o_kind            = head.kind;
    assign o_domain          = head.domain;
    assign o_handle          = head.handle;
    assign o_signed_value    = head.signed_value;
    assign o_running         = head.running;
    assign o_active          = head.active;
    assign o_complete        = head.complete;
    assign o_objective_total = head.objective_total;
    assign o_displayed       = head.displayed;
    assign o_completed       = head.completed;
    assign o_status          = head.status;
    assign o_last            = head.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= 3'(C_QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS |-> o_last)
        else $error("status result without last");

    a_eor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_record |=> o_valid)
        else $error("record end produced no result");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.a_valid || res.b_valid |-> !full)
        else $error("results formed while queue full");

endmodule

// ----- tb/tb_quest_record_byte_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quest_record_byte_decoder
// Feeds quest records byte by byte into the decoder and checks every header,
// objective and status result against an in-bench decode of the same bytes.
// Directed records cover field extremes, zero and oversized counts, records cut
// short at the domain byte, in the handle or an objective index, and records
// with extra bytes. Random records follow, idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_quest_record_byte_decoder;
    import qrbd_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_data_byte;
    logic               i_end_of_record;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_kind;
    logic [7:0]         o_domain;
    logic [63:0]        o_handle;
    logic signed [31:0] o_signed_value;
    logic               o_running;
    logic               o_active;
    logic               o_complete;
    logic [31:0]        o_objective_total;
    logic               o_displayed;
    logic               o_completed;
    logic [1:0]         o_status;
    logic               o_last;

    // Decode state kept alongside the block
    t_phase      dec_phase;
    logic [2:0]  dec_pos;
    logic [63:0] dec_shift;
    logic [31:0] dec_objs_left;
    logic [7:0]  dec_domain;
    logic [63:0] dec_handle;
    logic [31:0] dec_stage;
    logic [2:0]  dec_flags;

    t_result     awaited_decodes[$];
    logic [7:0]  pending_bytes[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    bit          idle_en = 1'b0;
    bit          stall_en = 1'b0;
    int          stall_left = 0;

    quest_record_byte_decoder i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_record   (i_end_of_record),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_domain          (o_domain),
        .o_handle          (o_handle),
        .o_signed_value    (o_signed_value),
        .o_running         (o_running),
        .o_active          (o_active),
        .o_complete        (o_complete),
        .o_objective_total (o_objective_total),
        .o_displayed       (o_displayed),
        .o_completed       (o_completed),
        .o_status          (o_status),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------
    function automatic void clear_decode();
        dec_phase     = PH_DOMAIN;
        dec_pos       = '0;
        dec_shift     = '0;
        dec_objs_left = '0;
        dec_domain    = '0;
        dec_handle    = '0;
        dec_stage     = '0;
        dec_flags     = '0;
    endfunction

    // Shift one byte into the little-endian accumulator; 1 when the field is full
    function automatic bit gather_byte(logic [7:0] b, int nbytes);
        int pos;
        pos = dec_pos;
        if (pos == 0)
            dec_shift = '0;
        dec_shift = dec_shift | (64'(b) << (8 * pos));
        if (pos + 1 >= nbytes) begin
            dec_pos = '0;
            return 1'b1;
        end
        dec_pos = 3'(pos + 1);
        return 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic eor);
        t_result produced[$];
        t_result r;
        r = '0;
        case (dec_phase)
            PH_DOMAIN: begin
                dec_domain = b;
                dec_pos    = '0;
                dec_phase  = PH_HANDLE;
            end
            PH_HANDLE: begin
                if (gather_byte(b, C_HANDLE_BYTES)) begin
                    dec_handle = dec_shift;
                    dec_phase  = PH_STAGE;
                end
            end
            PH_STAGE: begin
                if (gather_byte(b, C_WORD_BYTES)) begin
                    dec_stage = dec_shift[31:0];
                    dec_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                // Bits above the three defined flags are dropped
                dec_flags = b[2:0];
                dec_pos   = '0;
                dec_phase = PH_COUNT;
            end
            PH_COUNT: begin
                if (gather_byte(b, C_WORD_BYTES)) begin
                    dec_objs_left     = dec_shift[31:0];
                    r.kind            = KIND_HEADER;
                    r.domain          = dec_domain;
                    r.handle          = dec_handle;
                    r.signed_value    = dec_stage;
                    r.running         = (dec_flags & C_FLAG_RUNNING) != 0;
                    r.active          = (dec_flags & C_FLAG_ACTIVE) != 0;
                    r.complete        = (dec_flags & C_FLAG_COMPLETE) != 0;
                    r.objective_total = dec_objs_left;
                    produced = {produced, r};
                    if (dec_objs_left == 0)
                        dec_phase = PH_DONE;
                    else
                        dec_phase = PH_INDEX;
                end
            end
            PH_INDEX: begin
                if (gather_byte(b, C_INDEX_BYTES))
                    dec_phase = PH_OBJFLAGS;
            end
            PH_OBJFLAGS: begin
                r.kind         = KIND_OBJECTIVE;
                r.signed_value = dec_shift[31:0];
                r.displayed    = (b & C_OBJ_DISPLAYED) != 0;
                r.completed    = (b & C_OBJ_COMPLETED) != 0;
                produced = {produced, r};
                dec_pos       = '0;
                dec_objs_left = dec_objs_left - 1;
                if (dec_objs_left == 0)
                    dec_phase = PH_DONE;
                else
                    dec_phase = PH_INDEX;
            end
            PH_DONE: begin
                // Mark that bytes arrived past the end of the objectives
                dec_pos = 3'd1;
            end
        endcase

        if (eor) begin
            r      = '0;
            r.kind = KIND_STATUS;
            if (dec_phase != PH_DONE)
                r.status = ST_TRUNCATED;
            else if (dec_pos != 0)
                r.status = ST_TRAILING;
            else
                r.status = ST_OK;
            produced = {produced, r};
            dec_phase     = PH_DOMAIN;
            dec_pos       = '0;
            dec_shift     = '0;
            dec_objs_left = '0;
        end

        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
        awaited_decodes = {awaited_decodes, produced};
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check output transfers, then decode input transfers
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (awaited_decodes.size() == 0) begin
                    $error("kind: expected no result, actual %0d", o_kind);
                    fail_count++;
                end else begin
                    want = awaited_decodes.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("domain", want.domain, o_domain);
                    check_field("handle", want.handle, o_handle);
                    check_field("signed_value", want.signed_value, o_signed_value);
                    check_field("running", want.running, o_running);
                    check_field("active", want.active, o_active);
                    check_field("complete", want.complete, o_complete);
                    check_field("objective_total", want.objective_total,
                                o_objective_total);
                    check_field("displayed", want.displayed, o_displayed);
                    check_field("completed", want.completed, o_completed);
                    check_field("status", want.status, o_status);
                    check_field("last", want.last, o_last);
                end
            end
            if (i_valid && !o_stall)
                decode_byte(i_data_byte, i_end_of_record);
        end
    end

    // Output stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (stall_en && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(1, 7) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic eor);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_record <= eor;
        // Hold the byte until the transfer
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_pending();
        foreach (pending_bytes[i])
            send_byte(pending_bytes[i], i == pending_bytes.size() - 1);
        pending_bytes.delete();
    endtask

    function automatic void add_byte(logic [7:0] b);
        pending_bytes = {pending_bytes, b};
    endfunction

    function automatic void push_le(logic [63:0] value, int nbytes);
        for (int i = 0; i < nbytes; i++)
            add_byte(value[8 * i +: 8]);
    endfunction

    function automatic void add_header(logic [7:0] domain, logic [63:0] handle,
                                       logic [31:0] stage, logic [7:0] flags,
                                       logic [31:0] count);
        push_le(domain, 1);
        push_le(handle, C_HANDLE_BYTES);
        push_le(stage, C_WORD_BYTES);
        push_le(flags, 1);
        push_le(count, C_WORD_BYTES);
    endfunction

    function automatic void add_objective(logic [31:0] index, logic [7:0] flags);
        push_le(index, C_INDEX_BYTES);
        push_le(flags, 1);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Drop valid, then wait until every expected result has been taken
    task automatic wait_for_drain();
        @(negedge i_clk) i_valid <= 1'b0;
        while (awaited_decodes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_record();
        int shape;
        int n_obj;
        logic [31:0] count;
        shape = $urandom_range(0, 99);
        if (shape < 5) begin
            // Noise: random bytes of random length
            repeat ($urandom_range(1, 30))
                add_byte(8'($urandom));
        end else begin
            n_obj = $urandom_range(0, 3);
            count = n_obj;
            // Oversized count: objectives run out before the count does
            if (shape < 15)
                count = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom | 32'h10;
            add_header(8'($urandom), {corner_word(), corner_word()}, corner_word(),
                       8'($urandom), count);
            repeat (n_obj)
                add_objective(corner_word(), 8'($urandom));
            if (shape >= 15 && shape < 30) begin
                repeat ($urandom_range(1, pending_bytes.size() - 1))
                    void'(pending_bytes.pop_back());
            end else if (shape >= 30 && shape < 42) begin
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom));
            end
        end
        send_pending();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_header_extremes();
        // Zero count ending on the last count byte: header and ok together
        add_header(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 8'hFF, 32'd0);
        send_pending();
        // Zero count followed by one extra byte
        add_header(8'h00, 64'h0, 32'h7FFF_FFFF, 8'h00, 32'd0);
        add_byte(8'hA5);
        send_pending();
    endtask

    task automatic test_objective_extremes();
        add_header(8'h5A, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF, 8'h05, 32'd2);
        add_objective(32'hFFFF_FFFF, 8'hFF);
        add_objective(32'h0000_0000, 8'h00);
        send_pending();
        add_header(8'hA5, 64'h8000_0000_0000_0001, 32'd1, 8'hFA, 32'd2);
        add_objective(32'h8000_0000, 8'h01);
        add_objective(32'h7FFF_FFFF, 8'hFE);
        send_pending();
    endtask

    task automatic test_truncation();
        // End on the domain byte
        add_byte(8'h3C);
        send_pending();
        // End inside the handle
        push_le(8'h11, 1);
        push_le(64'hDEAD_BEEF, 4);
        send_pending();
        // Count larger than the objectives present
        add_header(8'h22, 64'h1, 32'h2, 8'h07, 32'hFFFF_FFFF);
        add_objective(32'h1234_5678, 8'h03);
        send_pending();
        // End inside an objective index
        add_header(8'h33, 64'h2, 32'h3, 8'h02, 32'd1);
        push_le(32'h00AB_CDEF, 2);
        send_pending();
    endtask

    task automatic test_trailing_bytes();
        add_header(8'h44, 64'hFEDC_BA98_7654_3210, 32'hFFFF_FF80, 8'h04, 32'd1);
        add_objective(32'h0000_0042, 8'h02);
        push_le(32'hFFFF_FF00, 3);
        send_pending();
    endtask

    // Hold the sender mid-record until every result has been taken
    task automatic test_drain_pause();
        add_header(8'h66, 64'h0F0F_0F0F_0F0F_0F0F, 32'd7, 8'h01, 32'd2);
        add_objective(32'd9, 8'h01);
        foreach (pending_bytes[i])
            send_byte(pending_bytes[i], 1'b0);
        pending_bytes.delete();
        wait_for_drain();
        add_objective(32'd10, 8'h02);
        add_byte(8'h00);
        send_pending();
    endtask

    task automatic test_random_records(int n_bytes);
        int target;
        int n_done;
        target = bytes_sent + n_bytes;
        n_done = 0;
        while (bytes_sent < target) begin
            send_random_record();
            n_done++;
            if (n_done % 25 == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_quiet_tail();
        idle_en  = 1'b0;
        stall_en = 1'b0;
        test_random_records(200);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_data_byte     = '0;
        i_end_of_record = 1'b0;
        clear_decode();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        idle_en  = 1'b1;
        stall_en = 1'b1;
        test_header_extremes();
        test_objective_extremes();
        test_truncation();
        test_trailing_bytes();
        test_drain_pause();
        test_random_records(1800);
        test_quiet_tail();

        @(negedge i_clk) i_valid <= 1'b0;
        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && awaited_decodes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
